@@ src/fba_pkg.sv @@
// Shared types and constants for the frame bitmap allocator.
package fba_pkg;

  localparam int unsigned FRAME_W = 15;
  localparam int unsigned COUNT_W = 16;

  localparam logic [1:0] ST_ALLOCATED     = 2'd0;
  localparam logic [1:0] ST_FREED         = 2'd1;
  localparam logic [1:0] ST_NO_CHANGE     = 2'd2;
  localparam logic [1:0] ST_OUT_OF_FRAMES = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 16'h8000;

  // Flags from the shared step unit back to the sequencer.
  typedef struct packed {
    logic fits;   // the word at base lies wholly below the target
    logic full;   // every frame in the checked word is used
  } scan_flags_t;

endpackage

@@ src/fba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fba_scan_unit.sv @@
// Shared step unit: next word base, bound compare and first-free-bit encoder.
module fba_scan_unit import fba_pkg::*; #(
  parameter int unsigned CMP_W     = 17,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned BIT_W     = 5
) (
  input  logic [CMP_W-1:0]     base_i,
  input  logic [CMP_W-1:0]     target_i,
  input  logic [WORD_BITS-1:0] word_i,
  output logic [CMP_W-1:0]     next_base_o,
  output scan_flags_t          flags_o,
  output logic [BIT_W-1:0]     first_zero_o
);

  logic [CMP_W-1:0] next_base;

  assign next_base     = base_i + CMP_W'(WORD_BITS);
  assign next_base_o   = next_base;
  assign flags_o.fits  = (next_base <= target_i);
  assign flags_o.full  = &word_i;

  // Lowest clear bit wins.
  always_comb begin
    first_zero_o = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!word_i[k]) begin
        first_zero_o = BIT_W'(k);
      end
    end
  end

endmodule

@@ src/frame_bitmap_allocator.sv @@
// Top level of the frame bitmap allocator: sequencer, bitmap RAM and result register.
// Allocate reads the bitmap words in order, one per cycle, at most MAX_FRAMES/WORD_BITS
//   = 1024 words, and reports out of frames when every word read is full.
// Free reads the frame's word, then writes it back; neither when it was never written.
// Other requests go straight to the result. One request in flight; the next is taken
//   once the result is parked in the output register, so a result waiting on the output
//   holds the input.
// Reset (async, active low): every frame reads free, frame_count = 32768, no result.
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 32768,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_count_we_i,
  input  logic [COUNT_W-1:0] frame_count_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [FRAME_W-1:0] current_frame_i,
  input  logic               is_kernel_i,
  input  logic               is_writeable_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [FRAME_W-1:0] frame_number_o,
  output logic               present_o,
  output logic               writable_o,
  output logic               user_access_o
);

  localparam int unsigned NUM_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned IDX_W     = $clog2(NUM_WORDS + 1);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned SPAN_W    = $clog2(MAX_FRAMES + WORD_BITS + 1);
  localparam int unsigned CMP_W     = (SPAN_W > COUNT_W) ? SPAN_W : COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FWALK,
    S_FRMW,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration.
  logic [COUNT_W-1:0] frame_count_q;

  // Captured request.
  logic [FRAME_W-1:0] cur_q;
  logic               kern_q;
  logic               wr_q;

  // Walk position: word index and its first frame number.
  logic [IDX_W-1:0]   idx_q;
  logic [CMP_W-1:0]   base_q;

  // Word in flight through the RAM read.
  logic               pend_q;
  logic               pend_live_q;
  logic [ADDR_W-1:0]  pend_idx_q;
  logic [CMP_W-1:0]   pend_base_q;
  logic [BIT_W-1:0]   bit_q;

  // Words below the fill mark have been written; the rest still read as free.
  logic [IDX_W-1:0]   fill_q;

  // Result staging and output register.
  logic [1:0]         res_status_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic               res_present_q;
  logic               res_writable_q;
  logic               res_user_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic               out_present_q;
  logic               out_writable_q;
  logic               out_user_q;

  // Datapath.
  logic [CMP_W-1:0]     target;
  logic [CMP_W-1:0]     next_base;
  scan_flags_t          flags;
  logic [BIT_W-1:0]     first_zero;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] chk_word;
  logic                 in_range;
  logic                 below_fill;
  logic                 issue_ok;
  logic                 found;
  logic [CMP_W-1:0]     frame_sum;
  logic [CMP_W-1:0]     free_word;
  logic                 free_in_range;
  logic                 free_below_fill;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;

  // Alloc bounds the scan by frame_count.
  assign target     = CMP_W'(frame_count_q);
  assign chk_word   = pend_live_q ? rdata : '0;
  assign in_range   = (idx_q < IDX_W'(NUM_WORDS));
  assign below_fill = (idx_q < fill_q);
  assign issue_ok   = in_range && flags.fits;
  assign found      = pend_q && !flags.full;
  assign frame_sum  = pend_base_q + CMP_W'(first_zero);

  // Word holding the frame to free; WORD_BITS is a power of two, so this is a shift.
  assign free_word       = CMP_W'(cur_q) >> BIT_W;
  assign free_in_range   = (free_word < CMP_W'(NUM_WORDS));
  assign free_below_fill = (free_word < CMP_W'(fill_q));

  fba_scan_unit #(
    .CMP_W     (CMP_W),
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_scan (
    .base_i       (base_q),
    .target_i     (target),
    .word_i       (chk_word),
    .next_base_o  (next_base),
    .flags_o      (flags),
    .first_zero_o (first_zero)
  );

  // RAM control: scan reads one word a cycle and writes back the claimed word;
  // free reads the frame's word once, then writes it back with the bit cleared.
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = idx_q[ADDR_W-1:0];
    ram_waddr = pend_idx_q;
    ram_wdata = chk_word | (WORD_BITS'(1) << first_zero);
    unique case (state_q)
      S_SCAN: begin
        ram_re = issue_ok && below_fill;
        ram_we = found;
      end
      S_FWALK: begin
        ram_re    = free_in_range && free_below_fill;
        ram_raddr = free_word[ADDR_W-1:0];
      end
      S_FRMW: begin
        ram_we    = 1'b1;
        ram_wdata = rdata & ~(WORD_BITS'(1) << bit_q);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_count_q  <= FRAME_COUNT_RST;
      fill_q         <= '0;
      pend_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (frame_count_we_i) begin
        frame_count_q <= frame_count_i;
      end

      // Drop the parked result once taken; S_DONE refills it itself.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cur_q          <= current_frame_i;
            kern_q         <= is_kernel_i;
            wr_q           <= is_writeable_i;
            idx_q          <= '0;
            base_q         <= '0;
            pend_q         <= 1'b0;
            res_status_q   <= ST_NO_CHANGE;
            res_frame_q    <= '0;
            res_present_q  <= 1'b0;
            res_writable_q <= 1'b0;
            res_user_q     <= 1'b0;
            if ((req_type_i == REQ_ALLOC) && (current_frame_i == '0)) begin
              state_q <= S_SCAN;
            end else if ((req_type_i == REQ_FREE) && (current_frame_i != '0)) begin
              state_q <= S_FWALK;
            end else begin
              state_q <= S_DONE;
            end
          end
        end

        S_SCAN: begin
          // Issue stage: advance to the next whole word below frame_count.
          pend_q <= issue_ok && !found;
          if (issue_ok) begin
            pend_live_q <= below_fill;
            pend_idx_q  <= idx_q[ADDR_W-1:0];
            pend_base_q <= base_q;
            idx_q       <= idx_q + IDX_W'(1);
            base_q      <= next_base;
          end
          // Check stage: claim the lowest free frame of the returned word.
          if (found) begin
            res_status_q   <= ST_ALLOCATED;
            res_frame_q    <= frame_sum[FRAME_W-1:0];
            res_present_q  <= 1'b1;
            res_writable_q <= wr_q;
            res_user_q     <= !kern_q;
            if (!(IDX_W'(pend_idx_q) < fill_q)) begin
              fill_q <= IDX_W'(pend_idx_q) + IDX_W'(1);
            end
            state_q <= S_DONE;
          end else if (!pend_q && !issue_ok) begin
            res_status_q <= ST_OUT_OF_FRAMES;
            state_q      <= S_DONE;
          end
        end

        S_FWALK: begin
          // Read the frame's word; a word at or above the fill mark is already free.
          res_status_q <= ST_FREED;
          if (free_in_range && free_below_fill) begin
            pend_idx_q <= free_word[ADDR_W-1:0];
            bit_q      <= cur_q[BIT_W-1:0];
            state_q    <= S_FRMW;
          end else begin
            state_q <= S_DONE;
          end
        end

        S_FRMW: begin
          state_q <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free or being emptied.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            out_status_q   <= res_status_q;
            out_frame_q    <= res_frame_q;
            out_present_q  <= res_present_q;
            out_writable_q <= res_writable_q;
            out_user_q     <= res_user_q;
            state_q        <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign frame_number_o = out_frame_q;
  assign present_o      = out_present_q;
  assign writable_o     = out_writable_q;
  assign user_access_o  = out_user_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= IDX_W'(NUM_WORDS))
    else $error("fill mark beyond bitmap depth");

  a_write_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (IDX_W'(ram_waddr) <= fill_q))
    else $error("bitmap write skips past the fill mark");

  a_pend_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (IDX_W'(pend_idx_q) + IDX_W'(1) == idx_q))
    else $error("checked word is not the one before the issue index");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one still in flight");

  a_alloc_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_ALLOCATED) |-> present_o)
    else $error("allocated result without present flag");
`endif

endmodule
